// ----- hw/rtl/b64se_pkg.sv -----
// ----------------------------------------------------------------------------
// b64se_pkg
// Types, character codes and the alphabet lookup shared by the encoder parts.
// ----------------------------------------------------------------------------
package b64se_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_t;

  // byte count of a queued group
  localparam logic [1:0] NB_ONE   = 2'd1;
  localparam logic [1:0] NB_TWO   = 2'd2;
  localparam logic [1:0] NB_THREE = 2'd3;

  // slice indices of the final and the third character of a group
  localparam logic [1:0] IDX_LAST = 2'd3;
  localparam logic [1:0] IDX_PAD2 = 2'd2;

  localparam logic [7:0] CHAR_PAD   = 8'h3D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef struct packed {
    logic [23:0] bits;
    logic [1:0]  nbytes;
    logic        last;
  } grp_t;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] v8;
    logic [7:0] c;
    v8 = {2'b00, v};
    if (v8 < 8'd26) begin
      c = CHAR_UA + v8;
    end else if (v8 < 8'd52) begin
      c = CHAR_LA + (v8 - 8'd26);
    end else if (v8 < 8'd62) begin
      c = CHAR_ZERO + (v8 - 8'd52);
    end else if (v8 == 8'd62) begin
      c = CHAR_PLUS;
    end else begin
      c = CHAR_SLASH;
    end
    return c;
  endfunction

endpackage

// ----- hw/rtl/b64se_front.sv -----
// ----------------------------------------------------------------------------
// b64se_front
// Gathers raw bytes into groups of up to three and pushes each closed group.
// ----------------------------------------------------------------------------
module b64se_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  b64se_pkg::in_t    in_data,
  output logic              push_valid,
  input  logic              push_ready,
  output b64se_pkg::grp_t   push_grp
);

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] pend_r [2];
  logic       take;
  logic       close;
  logic [7:0] b;

  assign in_ready   = push_ready;
  assign take       = in_valid && in_ready;
  assign b          = in_data.data_byte;
  assign close      = (cnt_r == 2'd2) || in_data.last_byte;
  assign push_valid = take && close;

  always_comb begin
    push_grp.last = in_data.last_byte;
    if (cnt_r == 2'd2) begin
      push_grp.bits   = {pend_r[0], pend_r[1], b};
      push_grp.nbytes = b64se_pkg::NB_THREE;
    end else if (cnt_r == 2'd1) begin
      push_grp.bits   = {pend_r[0], b, 8'h00};
      push_grp.nbytes = b64se_pkg::NB_TWO;
    end else begin
      push_grp.bits   = {b, 16'h0000};
      push_grp.nbytes = b64se_pkg::NB_ONE;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (take) begin
      cnt_nxt = close ? 2'd0 : cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && !close) begin
      pend_r[cnt_r[0]] <= b;
    end
  end

endmodule

// ----- hw/rtl/b64se_queue.sv -----
// ----------------------------------------------------------------------------
// b64se_queue
// Two-entry group queue between the byte front and the character back.
// ----------------------------------------------------------------------------
module b64se_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  b64se_pkg::grp_t   wr_grp,
  output logic              rd_valid,
  input  logic              rd_ready,
  output b64se_pkg::grp_t   rd_grp
);

  b64se_pkg::grp_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       wr_en, rd_en;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_grp   = mem_r[rd_ptr_r];
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_en ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = rd_en ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_grp;
    end
  end

endmodule

// ----- hw/rtl/b64se_back.sv -----
// ----------------------------------------------------------------------------
// b64se_back
// One group at a time; four characters, one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
module b64se_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  b64se_pkg::grp_t   pop_grp,
  output logic              out_valid,
  input  logic              out_ready,
  output b64se_pkg::out_t   out_data
);

  b64se_pkg::grp_t grp_r;
  b64se_pkg::out_t out_r, out_nxt;
  logic       busy_r, busy_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       adv;
  logic       load;
  logic       at_end;
  logic [5:0] slice;

  assign adv       = busy_r && (!out_valid_r || out_ready);
  assign at_end    = (idx_r == b64se_pkg::IDX_LAST);
  assign pop_ready = !busy_r || (adv && at_end);
  assign load      = pop_valid && pop_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    unique case (idx_r)
      2'd0:    slice = grp_r.bits[23:18];
      2'd1:    slice = grp_r.bits[17:12];
      2'd2:    slice = grp_r.bits[11:6];
      default: slice = grp_r.bits[5:0];
    endcase
  end

  always_comb begin
    out_nxt.last_char = grp_r.last && at_end;
    // missing bytes turn the tail slices into padding
    if ((grp_r.nbytes == b64se_pkg::NB_ONE && idx_r >= b64se_pkg::IDX_PAD2) ||
        (grp_r.nbytes == b64se_pkg::NB_TWO && at_end)) begin
      out_nxt.out_char = b64se_pkg::CHAR_PAD;
    end else begin
      out_nxt.out_char = b64se_pkg::b64_char(slice);
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = idx_r + 2'd1;
      if (at_end) begin
        busy_nxt = 1'b0;
      end
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load) begin
      busy_nxt = 1'b1;
      idx_nxt  = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= pop_grp;
    end
    if (adv) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ----- hw/rtl/base64_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder
// Streaming base64 encoder: raw bytes in, standard alphabet characters out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data) carries one byte per request with
// a flag on the final byte of a message. Output channel (out_valid/out_ready/
// out_data) carries one ASCII character per request, '=' padding included,
// with last_char set on the final character of the message.
// A byte that closes a group (third byte, or any flagged byte) passes through
// the queue entry, the back part's group register and the output register
// before its first character shows at out_valid; the other three follow one
// per cycle while out_ready is high. Bytes are taken every cycle while the
// two-entry group queue has room, so the output register sets throughput.
// Synchronous reset (rst_n low) empties the queue, drops any partial group
// and clears out_valid. When the receiver holds out_ready low, the current
// character stays put, the queue fills and in_ready then drops until a slot
// frees up. Each flagged byte ends its message; the next byte starts a new one.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  b64se_pkg::in_t    in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output b64se_pkg::out_t   out_data
);

  logic            push_valid, push_ready;
  b64se_pkg::grp_t push_grp;
  logic            pop_valid, pop_ready;
  b64se_pkg::grp_t pop_grp;

  b64se_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_grp   (push_grp)
  );

  b64se_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_grp   (push_grp),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready),
    .rd_grp   (pop_grp)
  );

  b64se_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_grp   (pop_grp),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // a closed group always finds room in the queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> push_ready)
    else $error("group pushed into a full queue");

  // reset leaves nothing on the output
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a partial group is only ever closed by a flagged byte
  a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push_valid && push_grp.nbytes != b64se_pkg::NB_THREE) |-> push_grp.last)
    else $error("partial group pushed without last flag");
`endif

endmodule

// ----- dv/b64se_checker.sv -----
// ----------------------------------------------------------------------------
// b64se_checker
// Watches both channels of the base64 encoder, predicts the characters that
// each accepted byte should produce and compares them in order as they leave.
// ----------------------------------------------------------------------------
module b64se_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  b64se_pkg::in_t       in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  b64se_pkg::out_t      out_data,
  output int                   mismatch_count,
  output int                   chars_owed
);

  localparam logic [511:0] SYMBOL_TABLE =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  logic [1:0]      held_count;
  logic [7:0]      held_bytes [2];
  b64se_pkg::out_t char_queue [$];
  int              fails;

  function automatic logic [7:0] symbol_of(input logic [5:0] v);
    return SYMBOL_TABLE[511 - 8 * int'(v) -: 8];
  endfunction

  // slices are taken msb first; slices past the real bytes become padding
  task automatic queue_group(input logic [23:0] bits, input logic [1:0] nbytes,
                             input logic fin);
    b64se_pkg::out_t c;
    for (int k = 0; k < 4; k++) begin
      c.out_char  = symbol_of(bits[23 - 6 * k -: 6]);
      if (k > int'(nbytes)) begin
        c.out_char = b64se_pkg::CHAR_PAD;
      end
      c.last_char = fin && (k == 3);
      char_queue.push_back(c);
    end
  endtask

  always @(posedge clk) begin : watch
    b64se_pkg::out_t want;
    logic [7:0]      b;
    logic            fin;
    if (!rst_n) begin
      held_count = 2'd0;
      char_queue.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (char_queue.size() == 0) begin
          if (fails < 10) begin
            $display("unexpected character %h last=%0b", out_data.out_char,
                     out_data.last_char);
          end
          fails++;
        end else begin
          want = char_queue.pop_front();
          if (out_data.out_char !== want.out_char ||
              out_data.last_char !== want.last_char) begin
            if (fails < 10) begin
              $display("character mismatch: expected %h last=%0b, got %h last=%0b",
                       want.out_char, want.last_char, out_data.out_char,
                       out_data.last_char);
            end
            fails++;
          end
        end
      end
      if (in_valid && in_ready) begin
        b   = in_data.data_byte;
        fin = in_data.last_byte;
        if (held_count == 2'd2) begin
          queue_group({held_bytes[0], held_bytes[1], b}, b64se_pkg::NB_THREE, fin);
          held_count = 2'd0;
        end else if (fin) begin
          if (held_count == 2'd0) begin
            queue_group({b, 16'h0000}, b64se_pkg::NB_ONE, 1'b1);
          end else begin
            queue_group({held_bytes[0], b, 8'h00}, b64se_pkg::NB_TWO, 1'b1);
          end
          held_count = 2'd0;
        end else begin
          held_bytes[held_count[0]] = b;
          held_count = held_count + 2'd1;
        end
      end
    end
    mismatch_count <= fails;
    chars_owed     <= char_queue.size();
  end

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Drives byte messages into the base64 encoder with random gaps and output
// stalls, one long output hold-off included; the checker beside the block
// predicts and compares every character, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT  = 40000;
  localparam int RANDOM_ITEMS = 125;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_START   = 90;
  localparam int HOLD_CYCLES  = 70;
  localparam int CALM_START   = 220;
  localparam int CALM_CYCLES  = 150;
  localparam int CALM_FIRST   = 100;
  localparam int CALM_LAST    = 150;

  // hand-picked messages of 1,1,2,3,3,4,5,6 bytes; a set bit ends a message
  localparam int DIR_COUNT = 25;
  localparam logic [8*DIR_COUNT-1:0] DIR_BYTES = {
    8'h00, 8'hFF, 8'hFB, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
    8'h80, 8'h7F, 8'h01, 8'h55, 8'h4D, 8'h61, 8'h6E, 8'h00, 8'hFE,
    8'hAA, 8'h55, 8'hF0, 8'h0F, 8'hC3, 8'h3C
  };
  localparam logic [DIR_COUNT-1:0] DIR_ENDS = 25'b1101001001000100001000001;

  logic            clk       = 1'b0;
  logic            rst_n     = 1'b0;
  logic            in_valid  = 1'b0;
  logic            in_ready;
  b64se_pkg::in_t  in_data   = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  b64se_pkg::out_t out_data;
  int              mismatch_count;
  int              chars_owed;
  int              cycle_count = 0;
  b64se_pkg::in_t  byte_queue [$];

  base64_stream_encoder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  b64se_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .mismatch_count(mismatch_count),
    .chars_owed    (chars_owed)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: one long hold-off so the block backs up, then a calm stretch
  initial begin : receiver
    int k;
    k = 0;
    forever begin
      @(posedge clk);
      if (k >= HOLD_START && k < HOLD_START + HOLD_CYCLES) begin
        out_ready <= 1'b0;
      end else if (k >= CALM_START && k < CALM_START + CALM_CYCLES) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 22);
      end
      k++;
    end
  end

  initial begin : sender
    b64se_pkg::in_t item;
    int             len;
    int             random_items;
    for (int i = 0; i < DIR_COUNT; i++) begin
      item.data_byte = DIR_BYTES[8 * (DIR_COUNT - 1 - i) +: 8];
      item.last_byte = DIR_ENDS[DIR_COUNT - 1 - i];
      byte_queue.push_back(item);
    end
    // mostly short messages so every group position ends a message often
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
      for (int j = 0; j < len; j++) begin
        item.data_byte = 8'($urandom_range(255));
        item.last_byte = (j == len - 1);
        byte_queue.push_back(item);
      end
      random_items += len;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    foreach (byte_queue[i]) begin
      if (!(i >= CALM_FIRST && i < CALM_LAST) && $urandom_range(99) < 22) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(3, 1)) @(posedge clk);
      end
      in_valid <= 1'b1;
      in_data  <= byte_queue[i];
      @(posedge clk);
      while (!in_ready) @(posedge clk);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (chars_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (chars_owed != 0) begin
      $display("%0d characters never came out", chars_owed);
    end
    if (mismatch_count == 0 && chars_owed == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/b64se_pkg.sv
hw/rtl/b64se_front.sv
hw/rtl/b64se_queue.sv
hw/rtl/b64se_back.sv
hw/rtl/base64_stream_encoder.sv
dv/b64se_checker.sv
dv/testbench.sv
